// ===== design/afr_pkg.sv =====
package afr_pkg;

   // Field widths fixed by the frame format.
   localparam int BYTE_W = 8;
   localparam int POS_W  = 6;

   // Default depth of the frame store.
   localparam int BUFFER_LEN_DEFAULT = 32;

   // Frame delimiters and the position of the address byte.
   localparam logic [BYTE_W-1:0] START_BYTE       = 8'h3C;
   localparam logic [BYTE_W-1:0] END_BYTE         = 8'h3E;
   localparam int                ADDRESS_POSITION = 2;

   // Register file layout.
   localparam int               CSR_ADDR_W  = 3;
   localparam int               CSR_DATA_W  = 32;
   localparam logic             REG_DEVICE_ADDRESS = 1'b0;

   // Command from the receive control to the frame store.
   typedef struct packed {
      logic              wr_en;
      logic [POS_W-1:0]  wr_pos;
      logic [BYTE_W-1:0] wr_byte;
      logic              start;
      logic [POS_W-1:0]  end_pos;
   } afr_cmd_type;

endpackage

// ===== design/addressed_frame_receiver.sv =====
// After the closing byte the frame store is read into the registered read data and then
// the output register; the frame follows one beat per cycle while rsp_stall is low.
// Throughput: one input byte per cycle while receiving; after a closing byte the input stays
// stalled until the last beat of the frame, read through the single store read port, is taken.
// Reset: synchronous, clears the control state and device address; the frame store is
// not cleared, since every byte read out was written earlier in the same frame.
module addressed_frame_receiver #(
   parameter int BUFFER_LEN = afr_pkg::BUFFER_LEN_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [afr_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [afr_pkg::BYTE_W-1:0]     rsp_frame_byte,
   output logic [afr_pkg::POS_W-1:0]      rsp_end_position,
   output logic                           rsp_last_byte,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [afr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [afr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [afr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import afr_pkg::*;

   localparam int               IDX_W    = $clog2(BUFFER_LEN);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(BUFFER_LEN - 2);
   localparam logic [IDX_W-1:0] ADDR_POS = IDX_W'(ADDRESS_POSITION);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RECV,
      ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] dev_addr_ff;
   afr_cmd_type       cmd;
   logic              drain_done;
   logic              req_acc;
   logic              csr_wr;

   // Configuration register; only the device address lives here.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= '0;
      end else if (csr_wr && paddr[2] == REG_DEVICE_ADDRESS) begin
         dev_addr_ff <= pwdata[BYTE_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? CSR_DATA_W'(dev_addr_ff) : '0;

   // Input is held off while a frame is being read out.
   assign req_stall = (state_ff == ST_DRAIN);
   assign req_acc   = req_valid && !req_stall;

   // Receive control: start detection, address filter, overflow and close.
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_rx_byte == START_BYTE) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_pos  = '0;
               cmd.wr_byte = req_rx_byte;
               pos_in      = IDX_W'(1);
               state_in    = ST_RECV;
            end
         end
         ST_RECV: begin
            if (req_acc) begin
               priority if (pos_ff == ADDR_POS && req_rx_byte != dev_addr_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_pos  = POS_W'(pos_ff);
                  cmd.wr_byte = req_rx_byte;
                  priority if (req_rx_byte == END_BYTE) begin
                     cmd.start   = 1'b1;
                     cmd.end_pos = POS_W'(pos_ff);
                     state_in    = ST_DRAIN;
                  end else if (pos_ff >= LAST_POS) begin
                     // The frame would not fit; drop it.
                     state_in = ST_IDLE;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   // Frame store and read-out path.
   afr_readout #(
      .BUFFER_LEN (BUFFER_LEN)
   ) u_readout (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .drain_done       (drain_done),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_end_position (rsp_end_position),
      .rsp_last_byte    (rsp_last_byte)
   );

   // No input beat is taken while a result beat is pending.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result beat is pending");

   // Result beats appear only during read-out.
   a_rsp_only_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DRAIN) |-> !rsp_valid)
      else $error("result beat outside read-out");

   // Once the last beat is taken, input is open again.
   a_reopen_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_byte) |=> !req_stall)
      else $error("input still stalled after the last beat");

   // Starting a read-out always comes from an accepted closing byte.
   a_start_on_close: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (req_acc && req_rx_byte == END_BYTE))
      else $error("read-out started without a closing byte");

endmodule

// ===== design/afr_readout.sv =====
module afr_readout #(
   parameter int BUFFER_LEN = afr_pkg::BUFFER_LEN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  afr_pkg::afr_cmd_type       cmd,
   output logic                       drain_done,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [afr_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic [afr_pkg::POS_W-1:0]  rsp_end_position,
   output logic                       rsp_last_byte
);
   import afr_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_LEN);

   // Frame store, one byte per position.
   logic [BYTE_W-1:0] mem [BUFFER_LEN];

   logic [IDX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic              act_ff, act_in;
   logic              pend_ff, pend_in;
   logic              rd_last_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_en;
   logic              load;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;

   // The output register takes the pending read data whenever it is free.
   assign load  = pend_ff && (!out_valid_ff || !rsp_stall);
   // A new read is issued only when its data register will be free next cycle.
   assign rd_en = act_ff && (!pend_ff || load);

   always_comb begin
      rd_addr_in = rd_addr_ff;
      end_in     = end_ff;
      act_in     = act_ff;
      if (cmd.start) begin
         rd_addr_in = '0;
         end_in     = cmd.end_pos[IDX_W-1:0];
         act_in     = 1'b1;
      end else if (rd_en) begin
         rd_addr_in = rd_addr_ff + 1'b1;
         act_in     = (rd_addr_ff != end_ff);
      end
      pend_in      = rd_en || (pend_ff && !load);
      out_valid_in = load || (out_valid_ff && rsp_stall);
   end

   // Control state of the read-out sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_addr_ff   <= '0;
         end_ff       <= '0;
         act_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_addr_ff   <= rd_addr_in;
         end_ff       <= end_in;
         act_ff       <= act_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Store write port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_pos[IDX_W-1:0]] <= cmd.wr_byte;
      end
   end

   // Store read port with registered data and the matching last flag.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_ff];
         rd_last_ff <= (rd_addr_ff == end_ff);
      end
   end

   // Output beat payload.
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= rd_data_ff;
         out_last_ff <= rd_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_byte   = out_byte_ff;
   assign rsp_last_byte    = out_last_ff;
   assign rsp_end_position = POS_W'(end_ff);
   assign drain_done       = out_valid_ff && !rsp_stall && out_last_ff;

endmodule

// ===== tb/tb_addressed_frame_receiver.sv =====
module tb_addressed_frame_receiver;
   import afr_pkg::*;

   localparam int FRAME_DEPTH    = BUFFER_LEN_DEFAULT;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 22;
   localparam int PHASES         = 5;

   // Register indexes; the second one lies outside the register file.
   localparam int unsigned DEVICE_ADDRESS_INDEX = 32'(REG_DEVICE_ADDRESS);
   localparam int unsigned UNUSED_INDEX         = 1;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   // One row of the directed table. typed_beats < 0 leaves the row to the frame model;
   // otherwise the row queues the beats of a frame made of its last typed_beats table bytes, none for 0.
   typedef struct packed {
      row_kind_type       kind;
      int unsigned        reg_index;
      logic [BYTE_W-1:0]  value;
      int                 typed_beats;
   } stim_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [POS_W-1:0]  end_position;
      logic              last_byte;
   } frame_beat_type;

   localparam int DIRECTED_ROWS = 27;

   stim_row_type directed [DIRECTED_ROWS] = '{
      // Bytes other than a start byte are ignored while idle.
      '{ROW_BYTE, 0, 8'h00, 0},
      '{ROW_BYTE, 0, 8'hFF, 0},
      '{ROW_BYTE, 0, END_BYTE, 0},
      // Empty frame.
      '{ROW_BYTE, 0, START_BYTE, 0},
      '{ROW_BYTE, 0, END_BYTE, 2},
      // Address mismatch, then a closing byte that arrives while idle.
      '{ROW_BYTE, 0, START_BYTE, 0},
      '{ROW_BYTE, 0, 8'h55, 0},
      '{ROW_BYTE, 0, 8'h01, 0},
      '{ROW_BYTE, 0, END_BYTE, 0},
      // A closing byte in the address slot that does not match is discarded.
      '{ROW_BYTE, 0, START_BYTE, 0},
      '{ROW_BYTE, 0, 8'hAA, 0},
      '{ROW_BYTE, 0, END_BYTE, 0},
      // Matching frame with a start byte stored as data.
      '{ROW_BYTE, 0, START_BYTE, -1},
      '{ROW_BYTE, 0, 8'h00, -1},
      '{ROW_BYTE, 0, 8'h00, -1},
      '{ROW_BYTE, 0, START_BYTE, -1},
      '{ROW_BYTE, 0, 8'hFF, -1},
      '{ROW_BYTE, 0, END_BYTE, -1},
      // Address equal to the closing byte: the frame ends in the address slot.
      '{ROW_CSR, DEVICE_ADDRESS_INDEX, END_BYTE, 0},
      '{ROW_BYTE, 0, START_BYTE, 0},
      '{ROW_BYTE, 0, 8'h80, 0},
      '{ROW_BYTE, 0, END_BYTE, 3},
      // A write outside the register file leaves the address alone.
      '{ROW_CSR, UNUSED_INDEX, 8'h11, 0},
      '{ROW_BYTE, 0, START_BYTE, 0},
      '{ROW_BYTE, 0, 8'h01, 0},
      '{ROW_BYTE, 0, END_BYTE, 3},
      '{ROW_CSR, DEVICE_ADDRESS_INDEX, 8'hFF, 0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_frame_byte;
   logic [POS_W-1:0]      rsp_end_position;
   logic                  rsp_last_byte;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Frame model state.
   logic [BYTE_W-1:0] model_store [FRAME_DEPTH];
   logic [BYTE_W-1:0] model_address;
   logic              model_receiving;
   int                model_wpos;

   frame_beat_type frame_beats_q [$];
   int             mismatches = 0;
   int             counted_bytes = 0;
   int             quiet_cycles = 0;
   int             stall_left = 0;
   bit             idle_on = 1'b1;

   addressed_frame_receiver #(
      .BUFFER_LEN(FRAME_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_end_position (rsp_end_position),
      .rsp_last_byte    (rsp_last_byte),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void go_idle_model();
      model_receiving = 1'b0;
      model_wpos = 0;
   endfunction

   // Advances the frame model by one accepted byte and, when keep is set, queues the
   // beats of a closed frame.
   function automatic void receive_frame_byte(input logic [BYTE_W-1:0] b, input bit keep);
      int pos;
      frame_beat_type beat;
      pos = model_wpos;
      if (!model_receiving) begin
         if (b == START_BYTE) begin
            model_store[0] = b;
            model_wpos = 1;
            model_receiving = 1'b1;
         end
      end else if (pos >= FRAME_DEPTH || (pos == ADDRESS_POSITION && b != model_address)) begin
         go_idle_model();
      end else begin
         model_store[pos] = b;
         if (b == END_BYTE) begin
            if (keep) begin
               for (int k = 0; k <= pos; k++) begin
                  beat.frame_byte = model_store[k];
                  beat.end_position = POS_W'(pos);
                  beat.last_byte = (k == pos);
                  frame_beats_q.push_back(beat);
               end
            end
            go_idle_model();
         end else if (pos + 1 > FRAME_DEPTH - 2) begin
            go_idle_model();
         end else begin
            model_wpos = pos + 1;
         end
      end
   endfunction

   // Sends one beat on the request channel, with an optional idle burst in front of it.
   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit keep);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (model_receiving || b == START_BYTE) begin
         counted_bytes++;
      end
      receive_frame_byte(b, keep);
      @(negedge clock);
   endtask

   // Writes a register once the block has drained, then reads the address back.
   task automatic write_register(input int unsigned idx, input logic [BYTE_W-1:0] value);
      req_valid <= 1'b0;
      while (frame_beats_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(idx * 4);
      pwdata <= {24'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == DEVICE_ADDRESS_INDEX) begin
         model_address = value;
      end
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_W'(DEVICE_ADDRESS_INDEX * 4);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[BYTE_W-1:0] !== model_address) begin
         report_mismatch($sformatf("device address reads %h, expected %h",
                                   prdata[BYTE_W-1:0], model_address));
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // A frame of len bytes; a len equal to the store depth or larger runs into the overflow drop.
   task automatic send_frame(input int len);
      logic [BYTE_W-1:0] b;
      send_byte(START_BYTE, 1'b1);
      for (int p = 1; p < len - 1 && p < FRAME_DEPTH - 1; p++) begin
         if (p == ADDRESS_POSITION) begin
            b = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(0, 255)) : model_address;
         end else begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == END_BYTE) begin
               b = ~b;
            end
         end
         send_byte(b, 1'b1);
      end
      if (len <= FRAME_DEPTH - 1) begin
         send_byte(END_BYTE, 1'b1);
      end
   endtask

   // One random stretch: mostly well-formed frames, some noise and cut-off frames.
   task automatic send_random_segment();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         len = $urandom_range(0, 19);
         if (len == 0) begin
            len = FRAME_DEPTH;
         end else if (len < 3) begin
            len = FRAME_DEPTH - 1;
         end else begin
            len = $urandom_range(2, 8);
         end
         send_frame(len);
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end else begin
         send_byte(START_BYTE, 1'b1);
         repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // Result channel stall bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Each accepted result beat is checked against the oldest expected beat.
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_beats_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", rsp_frame_byte));
         end else begin
            want = frame_beats_q.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               report_mismatch($sformatf("frame_byte %h, expected %h",
                                         rsp_frame_byte, want.frame_byte));
            end
            if (rsp_end_position !== want.end_position) begin
               report_mismatch($sformatf("end_position %0d, expected %0d",
                                         rsp_end_position, want.end_position));
            end
            if (rsp_last_byte !== want.last_byte) begin
               report_mismatch($sformatf("last_byte %b, expected %b",
                                         rsp_last_byte, want.last_byte));
            end
         end
      end
   end

   // The run ends if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_addressed_frame_receiver: errors");
         $finish;
      end
   end

   initial begin
      frame_beat_type beat;
      int n;
      int target;
      logic [BYTE_W-1:0] phase_address;
      model_address = '0;
      go_idle_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed[i].kind == ROW_CSR) begin
            write_register(directed[i].reg_index, directed[i].value);
         end else begin
            n = directed[i].typed_beats;
            for (int k = 0; k < n; k++) begin
               beat.frame_byte = directed[i - n + 1 + k].value;
               beat.end_position = POS_W'(n - 1);
               beat.last_byte = (k == n - 1);
               frame_beats_q.push_back(beat);
            end
            send_byte(directed[i].value, n < 0);
         end
      end

      // Random phases over several device addresses; the last one runs without idling.
      for (int ph = 0; ph < PHASES; ph++) begin
         unique case (ph)
            0: phase_address = 8'h00;
            1: phase_address = 8'hFF;
            2: phase_address = END_BYTE;
            3: phase_address = START_BYTE;
            default: begin
               phase_address = BYTE_W'($urandom_range(0, 255));
               idle_on = 1'b0;
            end
         endcase
         write_register(DEVICE_ADDRESS_INDEX, phase_address);
         target = counted_bytes + PHASE_BYTES;
         while (counted_bytes < target) send_random_segment();
         // A closing byte always leaves the receiver idle before the next write.
         if (model_receiving) begin
            send_byte(END_BYTE, 1'b1);
         end
      end

      req_valid <= 1'b0;
      while (frame_beats_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb_addressed_frame_receiver: clean");
      end else begin
         $display("tb_addressed_frame_receiver: errors");
      end
      $finish;
   end

endmodule
